// ===== rtl/rsr_pkg.sv =====
// ----------------------------------------------------------------------------
// rsr_pkg
// shared constants and types of the ring segment reverser
// ----------------------------------------------------------------------------
package rsr_pkg;

	localparam int RING_DEPTH = 1024;
	localparam int NODE_WIDTH = 16;
	localparam int ADDR_W     = $clog2(RING_DEPTH);
	localparam int LEN_W      = ADDR_W + 1;
	localparam int SPAN_W     = 16;
	localparam int OP_W       = 2;
	localparam int ST_W       = 2;

	localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
	localparam logic [OP_W-1:0] OP_READ   = 2'd1;
	localparam logic [OP_W-1:0] OP_STRICT = 2'd2;
	localparam logic [OP_W-1:0] OP_SMART  = 2'd3;

	localparam logic [ST_W-1:0] ST_DONE   = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
	localparam logic [ST_W-1:0] ST_REJECT = 2'd2;

	typedef logic [ADDR_W-1:0]     addr_t;
	typedef logic [NODE_WIDTH-1:0] node_t;

	typedef struct packed {
		logic  rd_en;
		addr_t rd_a_addr;
		addr_t rd_b_addr;
		logic  wr_en;
		addr_t wr_addr;
		node_t wr_data;
	} mem_req_t;

endpackage

// ===== rtl/rsr_req_if.sv =====
// ----------------------------------------------------------------------------
// rsr_req_if
// request channel: one operation item with valid and ready
// ----------------------------------------------------------------------------
interface rsr_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [9:0]  position;
	logic [15:0] node_value;
	logic [15:0] seg_start;
	logic [15:0] seg_end;

	modport source (output valid, opcode, position, node_value, seg_start, seg_end,
		input ready);
	modport sink (input valid, opcode, position, node_value, seg_start, seg_end,
		output ready);
endinterface

// ===== rtl/rsr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rsr_rsp_if
// response channel: one result item with valid and ready
// ----------------------------------------------------------------------------
interface rsr_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] read_value;
	logic [1:0]  status;
	logic        kept_direction;

	modport source (output valid, read_value, status, kept_direction, input ready);
	modport sink (input valid, read_value, status, kept_direction, output ready);
endinterface

// ===== rtl/ring_segment_reverser.sv =====
// ----------------------------------------------------------------------------
// ring_segment_reverser
// circular tour store with entry write/read and strict and smart span reversal
//
// req carries one operation item, rsp returns exactly one result item for it;
// both use valid/ready and move an item when both are high at a clock edge.
// cfg_we/cfg_wdata set the tour length; write it only while the block is idle.
// write and read: the item goes straight to S_DONE, which loads the result
// into the rsp register. reversal: decode in S_CHOOSE and S_CHECK (a rejected,
// empty or one-entry span goes on to S_DONE), the start rank modulo the tour
// length in the mod unit (skipped for a full-length span), setup in S_PTR and
// S_RD, then S_WX and S_WY per swapped pair, set by the single write port of
// the store, and S_DONE to load the result.
// one item is worked on at a time; req.ready is high only while idle.
// a finished result sits in the rsp register, so the next item is taken while
// the receiver stalls; a further result then waits until rsp is free.
// reset clears control state and sets the length to 1024; the store contents
// are undefined until written and there is no clearing pass.
// ----------------------------------------------------------------------------
module ring_segment_reverser
	import rsr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [LEN_W-1:0] cfg_wdata,
	rsr_req_if.sink          req,
	rsr_rsp_if.source        rsp
);

	typedef enum logic [3:0] {
		S_IDLE, S_CHOOSE, S_CHECK, S_DIV, S_PTR, S_RD, S_WX, S_WY, S_DONE
	} state_t;

	state_t             state_q;
	logic [LEN_W-1:0]   ring_len_q;
	logic [LEN_W-1:0]   n_eff;
	logic [OP_W-1:0]    op_q;
	logic [SPAN_W-1:0]  s_q;
	logic [SPAN_W-1:0]  e_q;
	logic [SPAN_W-1:0]  sp_q;
	logic [SPAN_W:0]    ep_q;
	logic [LEN_W-1:0]   sz_q;
	addr_t              first_q;
	addr_t              x_q;
	addr_t              y_q;
	logic [ADDR_W-1:0]  cnt_q;
	logic [ST_W-1:0]    st_q;
	logic               kept_q;
	logic               rd_sel_q;
	logic               rsp_valid_q;
	node_t              read_value_q;
	logic [ST_W-1:0]    status_q;
	logic               kept_out_q;

	logic               accept;
	logic               pos_ok;
	logic [SPAN_W-1:0]  span_d;
	logic [SPAN_W+1:0]  sz;
	logic [SPAN_W+1:0]  n_wide;
	logic [LEN_W:0]     ysum;
	logic [LEN_W:0]     ystart;
	logic [LEN_W-1:0]   x_inc;
	addr_t              x_nxt;
	addr_t              y_nxt;
	logic [LEN_W-1:0]   n_m1;
	logic               div_start;
	logic               div_done;
	addr_t              div_rem;
	logic               rsp_load;
	mem_req_t           mreq;
	node_t              rd_a_data;
	node_t              rd_b_data;

	always_comb begin
		if (ring_len_q == '0) begin
			n_eff = LEN_W'(1);
		end else if (ring_len_q > LEN_W'(RING_DEPTH)) begin
			n_eff = LEN_W'(RING_DEPTH);
		end else begin
			n_eff = ring_len_q;
		end
	end

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign pos_ok    = {1'b0, req.position} < n_eff;

	assign span_d = e_q - s_q;
	assign n_wide = {{(SPAN_W+2-LEN_W){1'b0}}, n_eff};
	assign sz     = {1'b0, ep_q} - {2'b0, sp_q} + (SPAN_W+2)'(1);

	assign ysum   = {2'b0, first_q} + {1'b0, sz_q} - (LEN_W+1)'(1);
	assign ystart = (ysum >= {1'b0, n_eff}) ? ysum - {1'b0, n_eff} : ysum;

	assign n_m1  = n_eff - LEN_W'(1);
	assign x_inc = {1'b0, x_q} + LEN_W'(1);
	assign x_nxt = (x_inc == n_eff) ? '0 : x_inc[ADDR_W-1:0];
	assign y_nxt = (y_q == '0) ? n_m1[ADDR_W-1:0] : y_q - 1'b1;

	assign div_start = (state_q == S_CHECK) && !sz[SPAN_W+1] && (sz > n_wide) == 1'b0
		&& (sz != '0) && (sz != (SPAN_W+2)'(1)) && (sz != n_wide);

	assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		mreq           = '0;
		mreq.rd_a_addr = x_q;
		mreq.rd_b_addr = y_q;
		mreq.wr_addr   = x_q;
		mreq.wr_data   = rd_b_data;
		unique case (state_q)
			S_IDLE: begin
				mreq.rd_a_addr = req.position;
				mreq.wr_addr   = req.position;
				mreq.wr_data   = req.node_value;
				mreq.wr_en     = accept && pos_ok && (req.opcode == OP_WRITE);
				mreq.rd_en     = accept && pos_ok && (req.opcode == OP_READ);
			end
			S_RD: begin
				mreq.rd_en = 1'b1;
			end
			S_WX: begin
				mreq.wr_en = 1'b1;
			end
			S_WY: begin
				mreq.wr_en     = 1'b1;
				mreq.wr_addr   = y_q;
				mreq.wr_data   = rd_a_data;
				mreq.rd_en     = (cnt_q != ADDR_W'(1));
				mreq.rd_a_addr = x_nxt;
				mreq.rd_b_addr = y_nxt;
			end
			default: begin
			end
		endcase
	end

	rsr_ring_mem u_ring_mem (
		.clk       (clk),
		.mreq      (mreq),
		.rd_a_data (rd_a_data),
		.rd_b_data (rd_b_data)
	);

	rsr_mod_unit u_mod_unit (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (sp_q),
		.divisor   (n_eff),
		.done      (div_done),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ring_len_q  <= LEN_W'(RING_DEPTH);
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				ring_len_q <= cfg_wdata;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.opcode == OP_WRITE || req.opcode == OP_READ) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_CHOOSE;
						end
					end
				end
				S_CHOOSE: begin
					if (op_q == OP_SMART && s_q > e_q) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (div_start) begin
						state_q <= S_DIV;
					end else if (sz == n_wide && sz != (SPAN_W+2)'(1)) begin
						state_q <= S_PTR;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_PTR;
					end
				end
				S_PTR: state_q <= S_RD;
				S_RD:  state_q <= S_WX;
				S_WX:  state_q <= S_WY;
				S_WY: begin
					state_q <= (cnt_q == ADDR_W'(1)) ? S_DONE : S_WX;
				end
				S_DONE: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= req.opcode;
			s_q      <= req.seg_start;
			e_q      <= req.seg_end;
			kept_q   <= 1'b0;
			rd_sel_q <= (req.opcode == OP_READ) && pos_ok;
			st_q     <= ((req.opcode == OP_WRITE || req.opcode == OP_READ) && !pos_ok)
				? ST_REJECT : ST_DONE;
		end
		if (state_q == S_CHOOSE) begin
			if (op_q == OP_SMART && s_q > e_q) begin
				st_q <= ST_REJECT;
			end else if (op_q == OP_SMART &&
				span_d > {{(SPAN_W-LEN_W){1'b0}}, n_eff >> 1}) begin
				sp_q <= e_q;
				ep_q <= {1'b0, s_q} + {{(SPAN_W+1-LEN_W){1'b0}}, n_eff};
			end else begin
				sp_q   <= s_q;
				ep_q   <= {1'b0, e_q};
				kept_q <= (op_q == OP_SMART);
			end
		end
		if (state_q == S_CHECK) begin
			sz_q    <= sz[LEN_W-1:0];
			first_q <= '0;
			if (!sz[SPAN_W+1] && sz > n_wide) begin
				st_q <= ST_REJECT;
			end else if (sz[SPAN_W+1] || sz == '0) begin
				st_q <= ST_EMPTY;
			end
		end
		if (state_q == S_DIV && div_done) begin
			first_q <= div_rem;
		end
		if (state_q == S_PTR) begin
			x_q   <= first_q;
			y_q   <= ystart[ADDR_W-1:0];
			cnt_q <= sz_q[LEN_W-1:1];
		end
		if (state_q == S_WY) begin
			x_q   <= x_nxt;
			y_q   <= y_nxt;
			cnt_q <= cnt_q - 1'b1;
		end
		if (rsp_load) begin
			read_value_q <= rd_sel_q ? rd_a_data : '0;
			status_q     <= st_q;
			kept_out_q   <= kept_q;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.read_value     = read_value_q;
	assign rsp.status         = status_q;
	assign rsp.kept_direction = kept_out_q;

endmodule

// ===== rtl/rsr_ring_mem.sv =====
// ----------------------------------------------------------------------------
// rsr_ring_mem
// tour store: two registered read ports, one write port
// ----------------------------------------------------------------------------
module rsr_ring_mem
	import rsr_pkg::*;
(
	input  logic     clk,
	input  mem_req_t mreq,
	output node_t    rd_a_data,
	output node_t    rd_b_data
);

	node_t mem [RING_DEPTH];
	node_t rd_a_q;
	node_t rd_b_q;

	always_ff @(posedge clk) begin
		if (mreq.wr_en) begin
			mem[mreq.wr_addr] <= mreq.wr_data;
		end
		if (mreq.rd_en) begin
			rd_a_q <= mem[mreq.rd_a_addr];
			rd_b_q <= mem[mreq.rd_b_addr];
		end
	end

	assign rd_a_data = rd_a_q;
	assign rd_b_data = rd_b_q;

endmodule

// ===== rtl/rsr_mod_unit.sv =====
// ----------------------------------------------------------------------------
// rsr_mod_unit
// bit-serial remainder of a span rank by the ring length, one bit per cycle
// ----------------------------------------------------------------------------
module rsr_mod_unit
	import rsr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SPAN_W-1:0] dividend,
	input  logic [LEN_W-1:0]  divisor,
	output logic              done,
	output addr_t             remainder
);

	localparam int CNT_W = $clog2(SPAN_W);

	logic [SPAN_W-1:0] dvd_q;
	addr_t             rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              run_q;
	logic              done_q;
	logic [LEN_W-1:0]  trial;
	logic [LEN_W-1:0]  diff;

	assign trial = {rem_q, dvd_q[SPAN_W-1]};
	assign diff  = trial - divisor;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(SPAN_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[SPAN_W-2:0], 1'b0};
			rem_q <= (trial >= divisor) ? diff[ADDR_W-1:0] : trial[ADDR_W-1:0];
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

// ===== rtl/rsr_checker.sv =====
// ----------------------------------------------------------------------------
// rsr_checker
// port-level checks of the ring segment reverser, bound to the top level
// ----------------------------------------------------------------------------
module rsr_checker
	import rsr_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [15:0] read_value,
	input logic [1:0]  status,
	input logic        kept_direction
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result item dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(read_value) && $stable(status)
			&& $stable(kept_direction))
		else $error("result item changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> status == ST_DONE || status == ST_EMPTY || status == ST_REJECT)
		else $error("unknown status code");

	a_kept_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && kept_direction |-> status == ST_DONE && read_value == '0)
		else $error("kept span reversal without done status");

	a_read_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && read_value != '0 |-> status == ST_DONE && !kept_direction)
		else $error("read data on a failed or reverse item");

endmodule

bind ring_segment_reverser rsr_checker u_rsr_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.read_value     (rsp.read_value),
	.status         (rsp.status),
	.kept_direction (rsp.kept_direction)
);

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// ring segment reverser: directed table then random operation items
//
// Drives request items over valid/ready and checks every response against a
// local tour model. The model tracks which entries hold written data, so
// in-range reads target only written entries, even after reversals move them.
// The tour length is changed between phases while the block is idle. Both
// channels idle at random, the receiver stalls once for a long stretch, and
// the last four phases run with no idling at all.
// ----------------------------------------------------------------------------
module testbench;
	import rsr_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES    = 400;
	localparam int HOLD_AT_ITEM   = 55;
	localparam int DRAIN_CYCLES   = 64;
	localparam int NUM_PHASES     = 12;

	typedef struct {
		logic [OP_W-1:0]   opcode;
		addr_t             position;
		node_t             node_value;
		logic [SPAN_W-1:0] seg_start;
		logic [SPAN_W-1:0] seg_end;
	} tour_op_t;

	typedef struct {
		node_t           read_value;
		logic [ST_W-1:0] status;
		logic            kept_direction;
	} tour_result_t;

	typedef struct {
		bit                is_len;
		logic [LEN_W-1:0]  len_value;
		logic [OP_W-1:0]   opcode;
		addr_t             position;
		node_t             node_value;
		logic [SPAN_W-1:0] seg_start;
		logic [SPAN_W-1:0] seg_end;
		bit                typed;
		node_t             read_value;
		logic [ST_W-1:0]   status;
		logic              kept_direction;
	} dir_row_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [LEN_W-1:0] cfg_wdata;

	rsr_req_if req_ch ();
	rsr_rsp_if rsp_ch ();

	ring_segment_reverser i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// tour model
	node_t            tour_mem [RING_DEPTH];
	bit               tour_written [RING_DEPTH];
	logic [LEN_W-1:0] len_reg = 11'd1024;

	tour_result_t pending_results [$];
	tour_result_t oldest;

	int  error_count;
	int  send_idle_pct;
	int  recv_idle_pct;
	int  hold_left;
	bit  hold_done;
	int  quiet_cycles;
	int  items_sent;
	int  reversals_sent;
	int  reads_sent;
	int  length_writes;
	int  status_seen [3];

	dir_row_t directed_rows [27] = '{
		'{0, 0, OP_WRITE,  0,    16'hFFFF, 0,        0,        1, 0,        ST_DONE,   0},
		'{0, 0, OP_WRITE,  1023, 0,        0,        0,        1, 0,        ST_DONE,   0},
		'{0, 0, OP_READ,   1023, 0,        0,        0,        1, 0,        ST_DONE,   0},
		'{0, 0, OP_READ,   0,    0,        0,        0,        1, 16'hFFFF, ST_DONE,   0},
		'{0, 0, OP_STRICT, 0,    0,        0,        1023,     1, 0,        ST_DONE,   0},
		'{0, 0, OP_READ,   0,    0,        0,        0,        0, 0,        ST_DONE,   0},
		'{0, 0, OP_STRICT, 0,    0,        16'hFFFF, 0,        1, 0,        ST_EMPTY,  0},
		'{0, 0, OP_STRICT, 0,    0,        0,        16'hFFFF, 1, 0,        ST_REJECT, 0},
		'{0, 0, OP_SMART,  0,    0,        5,        3,        1, 0,        ST_REJECT, 0},
		'{0, 0, OP_SMART,  0,    0,        0,        16'hFFFF, 0, 0,        ST_DONE,   0},
		'{1, 4, OP_WRITE,  0,    0,        0,        0,        0, 0,        ST_DONE,   0},
		'{0, 0, OP_WRITE,  4,    16'h5A5A, 0,        0,        1, 0,        ST_REJECT, 0},
		'{0, 0, OP_READ,   1023, 0,        0,        0,        1, 0,        ST_REJECT, 0},
		'{0, 0, OP_WRITE,  1,    16'h1111, 0,        0,        1, 0,        ST_DONE,   0},
		'{0, 0, OP_WRITE,  2,    16'h2222, 0,        0,        1, 0,        ST_DONE,   0},
		'{0, 0, OP_WRITE,  3,    16'h3333, 0,        0,        1, 0,        ST_DONE,   0},
		'{0, 0, OP_STRICT, 0,    0,        3,        5,        0, 0,        ST_DONE,   0},
		'{0, 0, OP_SMART,  0,    0,        1,        2,        0, 0,        ST_DONE,   0},
		'{0, 0, OP_SMART,  0,    0,        0,        3,        0, 0,        ST_DONE,   0},
		'{0, 0, OP_SMART,  0,    0,        0,        5,        0, 0,        ST_DONE,   0},
		'{0, 0, OP_READ,   0,    0,        0,        0,        0, 0,        ST_DONE,   0},
		'{0, 0, OP_READ,   1,    0,        0,        0,        0, 0,        ST_DONE,   0},
		'{0, 0, OP_READ,   2,    0,        0,        0,        0, 0,        ST_DONE,   0},
		'{0, 0, OP_READ,   3,    0,        0,        0,        0, 0,        ST_DONE,   0},
		'{1, 0, OP_WRITE,  0,    0,        0,        0,        0, 0,        ST_DONE,   0},
		'{0, 0, OP_STRICT, 0,    0,        7,        7,        0, 0,        ST_DONE,   0},
		'{0, 0, OP_READ,   0,    0,        0,        0,        0, 0,        ST_DONE,   0}
	};

	int length_plan [NUM_PHASES] = '{16, 1, 2, 3, 1024, 0, 37, 2047, 5, 100, 1023, 8};
	int count_plan [NUM_PHASES]  = '{100, 50, 70, 60, 50, 40, 120, 50, 80, 120, 60, 50};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int active_len();
		int n;
		n = int'(len_reg);
		if (n < 1) n = 1;
		if (n > RING_DEPTH) n = RING_DEPTH;
		return n;
	endfunction

	// swap count/2 pairs walking inward from first, wrapping at n
	function automatic void flip_run(int first, int count, int n);
		node_t t;
		bit    w;
		int    x;
		int    y;
		for (int i = 0; i < count / 2; i++) begin
			x = (first + i) % n;
			y = (first + count - 1 - i) % n;
			t = tour_mem[x];
			tour_mem[x] = tour_mem[y];
			tour_mem[y] = t;
			w = tour_written[x];
			tour_written[x] = tour_written[y];
			tour_written[y] = w;
		end
	endfunction

	function automatic logic [ST_W-1:0] reverse_span(int s, int e, int n);
		int count;
		count = e - s + 1;
		if (count > n) return ST_REJECT;
		if (count <= 0) return ST_EMPTY;
		if (count == n) flip_run(0, n, n);
		else if (count > 1) flip_run(s % n, count, n);
		return ST_DONE;
	endfunction

	function automatic tour_result_t tour_predict(tour_op_t c);
		tour_result_t r;
		int           n;
		int           s;
		int           e;
		n = active_len();
		s = int'(c.seg_start);
		e = int'(c.seg_end);
		r.read_value = '0;
		r.status = ST_DONE;
		r.kept_direction = 1'b0;
		case (c.opcode)
			OP_WRITE: begin
				if (c.position < n) begin
					tour_mem[c.position] = c.node_value;
					tour_written[c.position] = 1'b1;
				end else begin
					r.status = ST_REJECT;
				end
			end
			OP_READ: begin
				if (c.position < n) r.read_value = tour_mem[c.position];
				else r.status = ST_REJECT;
			end
			OP_STRICT: begin
				r.status = reverse_span(s, e, n);
			end
			default: begin
				if (s > e) begin
					r.status = ST_REJECT;
				end else if (e - s <= (n >> 1)) begin
					r.status = reverse_span(s, e, n);
					r.kept_direction = 1'b1;
				end else begin
					r.status = reverse_span(e, s + n, n);
				end
			end
		endcase
		return r;
	endfunction

	// mostly in-range spans and reads of written entries, some broken requests
	function automatic tour_op_t random_cmd();
		tour_op_t c;
		int       n;
		int       pick;
		int       mode;
		int       span;
		int       s;
		int       e;
		int       written_pos [$];
		n = active_len();
		for (int i = 0; i < n; i++) if (tour_written[i]) written_pos.push_back(i);
		c.opcode = OP_WRITE;
		c.position = addr_t'($urandom_range(n - 1));
		c.node_value = node_t'($urandom);
		c.seg_start = SPAN_W'($urandom);
		c.seg_end = SPAN_W'($urandom);
		pick = $urandom_range(99);
		if (pick < 20 || (pick < 45 && written_pos.size() == 0)) begin
			if ($urandom_range(9) == 0) c.position = addr_t'($urandom_range(RING_DEPTH - 1));
		end else if (pick < 45) begin
			c.opcode = OP_READ;
			if (n < RING_DEPTH && $urandom_range(9) == 0)
				c.position = addr_t'($urandom_range(RING_DEPTH - 1, n));
			else
				c.position = addr_t'(written_pos[$urandom_range(written_pos.size() - 1)]);
		end else begin
			s = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(3 * n);
			mode = $urandom_range(99);
			if (pick < 72) begin
				c.opcode = OP_STRICT;
				if (mode < 70) span = $urandom_range(n - 1);
				else if (mode < 82) span = n - 1;
				else if (mode < 92) span = n + $urandom_range(3);
				else span = -1 - $urandom_range(2);
			end else begin
				c.opcode = OP_SMART;
				if (mode < 78) span = $urandom_range(n + 2);
				else if (mode < 90) span = (n >> 1) + $urandom_range(1);
				else span = -1 - $urandom_range(2);
			end
			e = s + span;
			if (e > 65535) begin
				s = s - (e - 65535);
				e = 65535;
			end
			if (e < 0) begin
				s = s - e;
				e = 0;
			end
			c.seg_start = SPAN_W'(s);
			c.seg_end = SPAN_W'(e);
		end
		return c;
	endfunction

	task automatic send_cmd(tour_op_t c, bit typed, tour_result_t typed_res);
		tour_result_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= c.opcode;
		req_ch.position <= c.position;
		req_ch.node_value <= c.node_value;
		req_ch.seg_start <= c.seg_start;
		req_ch.seg_end <= c.seg_end;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		r = tour_predict(c);
		pending_results.push_back(typed ? typed_res : r);
		items_sent++;
		if (c.opcode == OP_STRICT || c.opcode == OP_SMART) reversals_sent++;
		if (c.opcode == OP_READ) reads_sent++;
	endtask

	// only while idle: every result back before the register moves
	task automatic set_length(logic [LEN_W-1:0] value);
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		len_reg = value;
		length_writes++;
	endtask

	// response side: check, then pick ready for the next edge
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (rsp_ch.status <= ST_REJECT) status_seen[rsp_ch.status]++;
				if (pending_results.size() == 0) begin
					$error("response item with no request waiting");
					error_count++;
				end else begin
					oldest = pending_results.pop_front();
					if (rsp_ch.read_value !== oldest.read_value) begin
						$error("read_value: expected %0h, got %0h",
							oldest.read_value, rsp_ch.read_value);
						error_count++;
					end
					if (rsp_ch.status !== oldest.status) begin
						$error("status: expected %0d, got %0d",
							oldest.status, rsp_ch.status);
						error_count++;
					end
					if (rsp_ch.kept_direction !== oldest.kept_direction) begin
						$error("kept_direction: expected %0d, got %0d",
							oldest.kept_direction, rsp_ch.kept_direction);
						error_count++;
					end
				end
			end
			// long receiver stall to back the block up into the request side
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", quiet_cycles);
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		tour_op_t     c;
		tour_result_t want;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		req_ch.valid <= 1'b0;
		req_ch.opcode <= OP_WRITE;
		req_ch.position <= '0;
		req_ch.node_value <= '0;
		req_ch.seg_start <= '0;
		req_ch.seg_end <= '0;
		send_idle_pct = 24;
		recv_idle_pct = 48;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_len) begin
				set_length(directed_rows[i].len_value);
			end else begin
				c.opcode = directed_rows[i].opcode;
				c.position = directed_rows[i].position;
				c.node_value = directed_rows[i].node_value;
				c.seg_start = directed_rows[i].seg_start;
				c.seg_end = directed_rows[i].seg_end;
				want.read_value = directed_rows[i].read_value;
				want.status = directed_rows[i].status;
				want.kept_direction = directed_rows[i].kept_direction;
				send_cmd(c, directed_rows[i].typed, want);
			end
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p < 4) begin
				send_idle_pct = 24;
				recv_idle_pct = 48;
			end else if (p < 8) begin
				send_idle_pct = 48;
				recv_idle_pct = 24;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			set_length(LEN_W'(length_plan[p]));
			for (int k = 0; k < count_plan[p]; k++) begin
				send_cmd(random_cmd(), 1'b0, want);
			end
		end

		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("ran %0d items: %0d span reversals, %0d reads, %0d length settings",
			items_sent, reversals_sent, reads_sent, length_writes);
		$display("responses by status: done %0d, empty %0d, rejected %0d",
			status_seen[0], status_seen[1], status_seen[2]);
		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/rsr_pkg.sv
rtl/rsr_req_if.sv
rtl/rsr_rsp_if.sv
rtl/rsr_ring_mem.sv
rtl/rsr_mod_unit.sv
rtl/ring_segment_reverser.sv
rtl/rsr_checker.sv
sim/testbench.sv
